// File: src/lkr_pkg.sv
// ----------------------------------------------------------------------------
// lkr_pkg
// Types and codes shared by the LRU-K frame replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package lkr_pkg;

  localparam int ACTION_W = 2;
  localparam int FRAME_W  = 6;
  localparam int HIST_W   = 4;
  localparam int FIU_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam int FRAME_COUNT = 1 << FRAME_W;

  localparam logic [ACTION_W-1:0] ACT_ACCESS = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MARK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_EVICT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

  localparam logic [HIST_W-1:0] HISTORY_DEPTH_RESET = 4'd2;
  localparam logic [FIU_W-1:0]  FRAMES_IN_USE_RESET = 7'd64;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCESS,
    OP_MARK,
    OP_UNMARK,
    OP_FORGET
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [FRAME_W-1:0]  frame;
    logic [HIST_W-1:0]   hist;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

// File: src/lkr_cmd_if.sv
// ----------------------------------------------------------------------------
// lkr_cmd_if
// Action channel: valid/ready with action, frame and mark payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkr_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [lkr_pkg::ACTION_W-1:0] action;
  logic [lkr_pkg::FRAME_W-1:0]  frame;
  logic                         make_evictable;

  modport source (output valid, output action, output frame, output make_evictable,
                  input ready);
  modport sink   (input valid, input action, input frame, input make_evictable,
                  output ready);
endinterface

`default_nettype wire

// File: src/lkr_res_if.sv
// ----------------------------------------------------------------------------
// lkr_res_if
// Result channel: valid/ready with eviction outcome and marked count.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkr_res_if;
  logic                        valid;
  logic                        ready;
  logic                        evicted;
  logic [lkr_pkg::FRAME_W-1:0] victim_frame;
  logic [lkr_pkg::COUNT_W-1:0] evictable_count;

  modport source (output valid, output evicted, output victim_frame,
                  output evictable_count, input ready);
  modport sink   (input valid, input evicted, input victim_frame,
                  input evictable_count, output ready);
endinterface

`default_nettype wire

// File: src/lkr_cell.sv
// ----------------------------------------------------------------------------
// lkr_cell
// Per-frame state cell; merges the passing victim token with its own frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lkr_cell #(
  parameter int IDX         = 0,
  parameter int STAMP_WIDTH = 48
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire  lkr_pkg::op_t                op,
  input  wire  [STAMP_WIDTH-1:0]            stamp,
  input  wire                               tv_in,
  input  wire                               tf_in,
  input  wire                               tp_in,
  input  wire  [lkr_pkg::FRAME_W-1:0]       ti_in,
  input  wire  [STAMP_WIDTH-1:0]            ts_in,
  output logic                              tv_out,
  output logic                              tf_out,
  output logic                              tp_out,
  output logic [lkr_pkg::FRAME_W-1:0]       ti_out,
  output logic [STAMP_WIDTH-1:0]            ts_out,
  output logic                              inc,
  output logic                              dec
);
  import lkr_pkg::*;

  logic                   tracked;
  logic                   promoted;
  logic                   mark;
  logic [HIST_W-1:0]      cnt;
  logic [STAMP_WIDTH-1:0] first_stamp;
  logic [STAMP_WIDTH-1:0] last_stamp;

  logic                   sel;
  logic [HIST_W-1:0]      cnt_inc;
  logic                   prom_hit;
  logic [STAMP_WIDTH-1:0] key;
  logic                   cand;
  logic                   take;

  assign sel      = (int'(op.frame) == IDX);
  assign cnt_inc  = (tracked ? cnt : '0) + 1'b1;
  assign prom_hit = (cnt_inc >= op.hist) || (cnt_inc == '0);
  assign key      = promoted ? last_stamp : first_stamp;
  assign cand     = tracked && mark;
  assign take     = cand && (!tf_in || (!promoted && tp_in) ||
                             ((promoted == tp_in) && (key < ts_in)));

  assign inc = sel && (op.kind == OP_MARK) && tracked && !mark;
  assign dec = sel && ((op.kind == OP_UNMARK) || (op.kind == OP_FORGET)) && mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked  <= 1'b0;
      promoted <= 1'b0;
      mark     <= 1'b0;
      cnt      <= '0;
      tv_out   <= 1'b0;
    end else begin
      tv_out <= tv_in;
      if (sel) begin
        case (op.kind)
          OP_ACCESS: begin
            if (!promoted) begin
              tracked <= 1'b1;
              cnt     <= cnt_inc;
              if (prom_hit) begin
                promoted <= 1'b1;
              end
            end
          end
          OP_MARK: begin
            if (tracked) begin
              mark <= 1'b1;
            end
          end
          OP_UNMARK: begin
            mark <= 1'b0;
          end
          OP_FORGET: begin
            mark     <= 1'b0;
            tracked  <= 1'b0;
            promoted <= 1'b0;
            cnt      <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && (op.kind == OP_ACCESS)) begin
      if (promoted) begin
        last_stamp <= stamp;
      end else begin
        if (!tracked) begin
          first_stamp <= stamp;
        end
        if (prom_hit) begin
          last_stamp <= stamp;
        end
      end
    end
    tf_out <= tf_in || cand;
    tp_out <= take ? promoted : tp_in;
    ti_out <= take ? FRAME_W'(IDX) : ti_in;
    ts_out <= take ? key : ts_in;
  end

endmodule

`default_nettype wire

// File: src/lru_k_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer_core
// LRU-K replacement policy over a row of per-frame cells.
// ----------------------------------------------------------------------------
// Actions arrive on cmd (valid/ready); each accepted beat yields exactly one
// result beat on res. Configuration (history_depth at index 0, frames_in_use
// at index 1) is to be written through cfg_we/cfg_index/cfg_data while idle;
// the block itself does not enforce this. Access, mark and remove update
// the addressed cell in the accept cycle; the block then waits in HOLD
// until the result moves to the output register and takes no new beat
// before that. Evict sends a victim token down the chain of 64 frame
// cells, one cell per cycle, each cell keeping the better of the token
// and its own frame; after the scan the block likewise waits in HOLD and
// takes no new beat until the result moves to the output register.
// The result sits in an output register, so a new beat is accepted while a
// finished result waits; the next result holds until res.ready is seen.
// Synchronous reset clears all frames, the stamp and the marked count and
// restores the register defaults; cmd.ready stays low during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_k_frame_replacer_core #(
  parameter int STAMP_WIDTH = 48
) (
  input  wire                             clk,
  input  wire                             rst,
  lkr_cmd_if.sink                         cmd,
  lkr_res_if.source                       res,
  input  wire                             cfg_we,
  input  wire  [lkr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [lkr_pkg::CFG_W-1:0]       cfg_data
);
  import lkr_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [HIST_W-1:0]      history_depth;
  logic [FIU_W-1:0]       frames_in_use;
  logic [STAMP_WIDTH-1:0] stamp;
  logic [COUNT_W-1:0]     marked_total;
  logic [COUNT_W-1:0]     marked_total_next;

  logic                   res_evicted;
  logic [FRAME_W-1:0]     res_victim;
  logic [COUNT_W-1:0]     res_count;

  logic                   accept;
  logic                   scan_done;
  logic                   out_load;
  op_t                    op;

  logic [FRAME_COUNT:0]   tv;
  logic [FRAME_COUNT:0]   tf;
  logic [FRAME_COUNT:0]   tp;
  logic [FRAME_W-1:0]     ti [FRAME_COUNT+1];
  logic [STAMP_WIDTH-1:0] ts [FRAME_COUNT+1];
  logic [FRAME_COUNT-1:0] inc_vec;
  logic [FRAME_COUNT-1:0] dec_vec;

  assign accept    = cmd.valid && cmd.ready;
  assign scan_done = (state == ST_SCAN) && tv[FRAME_COUNT];

  assign tv[0] = accept && (cmd.action == ACT_EVICT);
  assign tf[0] = 1'b0;
  assign tp[0] = 1'b0;
  assign ti[0] = '0;
  assign ts[0] = '0;

  always_comb begin
    op.kind  = OP_NONE;
    op.frame = cmd.frame;
    op.hist  = history_depth;
    if (accept) begin
      unique case (cmd.action)
        ACT_ACCESS: begin
          if ({1'b0, cmd.frame} < frames_in_use) begin
            op.kind = OP_ACCESS;
          end
        end
        ACT_MARK:   op.kind = cmd.make_evictable ? OP_MARK : OP_UNMARK;
        ACT_REMOVE: op.kind = OP_FORGET;
        default:    op.kind = OP_NONE;
      endcase
    end else if (scan_done && tf[FRAME_COUNT]) begin
      op.kind  = OP_FORGET;
      op.frame = ti[FRAME_COUNT];
    end
  end

  for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
    lkr_cell #(
      .IDX         (g),
      .STAMP_WIDTH (STAMP_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .op     (op),
      .stamp  (stamp + 1'b1),
      .tv_in  (tv[g]),
      .tf_in  (tf[g]),
      .tp_in  (tp[g]),
      .ti_in  (ti[g]),
      .ts_in  (ts[g]),
      .tv_out (tv[g+1]),
      .tf_out (tf[g+1]),
      .tp_out (tp[g+1]),
      .ti_out (ti[g+1]),
      .ts_out (ts[g+1]),
      .inc    (inc_vec[g]),
      .dec    (dec_vec[g])
    );
  end

  assign marked_total_next = marked_total + COUNT_W'(|inc_vec) - COUNT_W'(|dec_vec);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd.action == ACT_EVICT) ? ST_SCAN : ST_HOLD;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = (state == ST_IDLE) && !rst;
    out_load  = (state == ST_HOLD) && (!res.valid || res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      history_depth <= HISTORY_DEPTH_RESET;
      frames_in_use <= FRAMES_IN_USE_RESET;
      stamp         <= '0;
      marked_total  <= '0;
      res.valid     <= 1'b0;
    end else begin
      state        <= state_next;
      marked_total <= marked_total_next;
      if (accept) begin
        stamp <= stamp + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HISTORY_DEPTH: history_depth <= cfg_data[HIST_W-1:0];
          REG_FRAMES_IN_USE: frames_in_use <= cfg_data[FIU_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_evicted <= 1'b0;
      res_victim  <= '0;
      res_count   <= marked_total_next;
    end else if (scan_done) begin
      res_evicted <= tf[FRAME_COUNT];
      res_victim  <= tf[FRAME_COUNT] ? ti[FRAME_COUNT] : '0;
      res_count   <= marked_total_next;
    end
    if (out_load) begin
      res.evicted         <= res_evicted;
      res.victim_frame    <= res_victim;
      res.evictable_count <= res_count;
    end
  end

endmodule

`default_nettype wire
